### hw/rtl/imurvc_pkg.sv
// Shared types and constants for the orientation sensor frame parser.
// No dependencies; used by imurvc_core and imu_rvc_frame_parser.
`default_nettype none

package imurvc_pkg;

  // Input beat operation codes.
  typedef enum logic [1:0] {
    OP_RX_BYTE  = 2'd0,
    OP_LINE_ERR = 2'd1,
    OP_SWITCH   = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  localparam logic [7:0] HeaderByte = 8'hAA;
  localparam int         FrameLen   = 19;
  localparam logic [4:0] CsumPos    = 5'(FrameLen - 1);
  localparam logic [4:0] WordFirst  = 5'd3;
  localparam logic [4:0] WordLast   = 5'd14;
  localparam logic [4:0] WordBase   = 5'd4;
  localparam int         WordCount  = 6;

  // One input beat.
  typedef struct packed {
    op_t        op;
    logic [7:0] rx_data;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic               checksum_ok;
    logic               source;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } out_t;

  // Parser state passed between the top level and the step logic.
  typedef struct packed {
    logic [4:0]                  pos;
    logic [7:0]                  sum;
    logic                        src;
    logic [7:0]                  low_hold;
    logic [WordCount-1:0][15:0]  words;
  } parser_state_t;

endpackage

`default_nettype wire

### hw/rtl/imurvc_core.sv
// Combinational step logic of the frame parser: next state and result for one beat.
// Depends on imurvc_pkg.
`default_nettype none

module imurvc_core (
  input  wire imurvc_pkg::in_t           item,
  input  wire imurvc_pkg::parser_state_t cur,
  output imurvc_pkg::parser_state_t      nxt,
  output logic                           res_vld,
  output imurvc_pkg::out_t               res
);

  logic [7:0] b;
  logic [4:0] word_off;
  logic [2:0] widx;

  assign b        = item.rx_data;
  assign word_off = cur.pos - imurvc_pkg::WordBase;
  assign widx     = word_off[3:1];

  // The result fields are always formed; res_vld says whether they count.
  always_comb begin
    res.checksum_ok = (cur.sum == b);
    res.source      = cur.src;
    res.yaw         = cur.words[0];
    res.pitch       = cur.words[1];
    res.roll        = cur.words[2];
    res.accel_x     = cur.words[3];
    res.accel_y     = cur.words[4];
    res.accel_z     = cur.words[5];
  end

  // Next state for the beat.
  always_comb begin
    nxt     = cur;
    res_vld = 1'b0;
    unique case (item.op)
      imurvc_pkg::OP_LINE_ERR: begin
        nxt.pos = '0;
        nxt.sum = '0;
      end
      imurvc_pkg::OP_SWITCH: begin
        nxt.src = ~cur.src;
        nxt.pos = '0;
        nxt.sum = '0;
      end
      imurvc_pkg::OP_RX_BYTE: begin
        if (cur.pos == 5'd0) begin
          // Hunting for the first header byte.
          if (b == imurvc_pkg::HeaderByte) nxt.pos = 5'd1;
          nxt.sum = '0;
        end else if (cur.pos == 5'd1) begin
          // Second header byte, or back to the hunt.
          nxt.pos = (b == imurvc_pkg::HeaderByte) ? 5'd2 : 5'd0;
          nxt.sum = '0;
        end else if (cur.pos >= imurvc_pkg::CsumPos) begin
          // Checksum byte closes the frame.
          res_vld = 1'b1;
          nxt.pos = '0;
          nxt.sum = '0;
        end else begin
          nxt.sum = cur.sum + b;
          if (cur.pos >= imurvc_pkg::WordFirst && cur.pos <= imurvc_pkg::WordLast) begin
            if (cur.pos[0]) begin
              nxt.low_hold = b;
            end else begin
              nxt.words[widx] = {b, cur.low_hold};
            end
          end
          nxt.pos = cur.pos + 5'd1;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/imu_rvc_frame_parser.sv
// Top level of the orientation sensor frame parser: handshakes and registers.
// Depends on imurvc_pkg and imurvc_core.
`default_nettype none

// Takes one beat per clock cycle (a byte, a line error or a source switch) and
// gives one result beat for each 19-byte frame, on the beat carrying the checksum
// byte. A beat is held in an input register, processed by the step logic from
// there, and its result lands in the output register that drives the outputs.
// The input stays open while a result waits, and only stalls when both the input
// register holds a result-making beat and the output register is still occupied
// and not taken. The six data words come out raw, whether or not the checksum
// matched.
module imu_rvc_frame_parser (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire imurvc_pkg::in_t  in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output imurvc_pkg::out_t      out_data
);

  imurvc_pkg::in_t           in_r;
  logic                      in_vld_r;
  imurvc_pkg::parser_state_t st_r;
  imurvc_pkg::parser_state_t st_nxt;
  imurvc_pkg::out_t          out_r;
  imurvc_pkg::out_t          res;
  logic                      out_vld_r;
  logic                      res_vld;
  logic                      drain;

  imurvc_core u_core (
    .item    (in_r),
    .cur     (st_r),
    .nxt     (st_nxt),
    .res_vld (res_vld),
    .res     (res)
  );

  // The held beat retires unless its result has nowhere to go.
  assign drain    = in_vld_r && (!res_vld || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || drain;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  // Parser state: control fields reset, captured bytes do not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.pos <= '0;
      st_r.sum <= '0;
      st_r.src <= 1'b0;
    end else if (drain) begin
      st_r <= st_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (drain && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // The frame position never runs past the checksum byte.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pos <= imurvc_pkg::CsumPos)
    else $error("frame position out of range");

  // A finished frame shows up at the output and the hunt restarts.
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (drain && res_vld) |=> (out_valid && st_r.pos == 5'd0 && st_r.sum == 8'd0))
    else $error("frame end not delivered");

  // Input only stalls behind a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && res_vld && out_vld_r && !out_ready))
    else $error("input stalled without cause");

  // A line error restarts assembly and keeps the source.
  a_line_err: assert property (@(posedge clk) disable iff (!rst_n)
    (drain && in_r.op == imurvc_pkg::OP_LINE_ERR) |=>
      (st_r.pos == 5'd0 && st_r.sum == 8'd0 && st_r.src == $past(st_r.src)))
    else $error("line error did not restart assembly");

endmodule

`default_nettype wire
